// ===== hw/rtl/mfcp_pkg.sv =====
// types, codes and constants shared by the marker framed command parser
package mfcp_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned MS_W     = 32;
   localparam int unsigned COUNT_W  = 32;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [BYTE_W-1:0] MARKER_RESET  = 8'hFF;
   localparam logic [MS_W-1:0]   TIMEOUT_RESET = 32'd100;

   localparam logic [1:0] FUNC_BYTE  = 2'd0;
   localparam logic [1:0] FUNC_CHECK = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   localparam logic [1:0] EV_NONE        = 2'd0;
   localparam logic [1:0] EV_FRAME       = 2'd1;
   localparam logic [1:0] EV_BAD_TRAILER = 2'd2;
   localparam logic [1:0] EV_TIMEOUT     = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_MARKER  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_LIMIT = 1'd1;

   typedef struct packed {
      logic [1:0]        func;
      logic [BYTE_W-1:0] rx_byte;
      logic [MS_W-1:0]   now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]         event_res;
      logic [BYTE_W-1:0]  frame_cmd;
      logic [BYTE_W-1:0]  frame_data;
      logic [COUNT_W-1:0] timeout_drops;
      logic [COUNT_W-1:0] error_drops;
   } rsp_type;

   typedef struct packed {
      logic [BYTE_W-1:0] frame_marker;
      logic [MS_W-1:0]   timeout_limit_ms;
   } cfg_type;

endpackage

// ===== hw/rtl/mfcp_csr.sv =====
// configuration registers: frame marker and timeout limit
module mfcp_csr
   import mfcp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   logic [BYTE_W-1:0] marker_ff, marker_in;
   logic [MS_W-1:0]   limit_ff, limit_in;

   assign csr_ready = 1'b1;

   always_comb begin
      marker_in = marker_ff;
      limit_in  = limit_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_MARKER:  marker_in = csr_wdata[BYTE_W-1:0];
            CSR_TIMEOUT_LIMIT: limit_in  = csr_wdata[MS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= MARKER_RESET;
         limit_ff  <= TIMEOUT_RESET;
      end else begin
         marker_ff <= marker_in;
         limit_ff  <= limit_in;
      end
   end

   assign cfg.frame_marker     = marker_ff;
   assign cfg.timeout_limit_ms = limit_ff;

endmodule

// ===== hw/rtl/mfcp_parser.sv =====
// frame parser state and single-pass result logic
module mfcp_parser
   import mfcp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_MARK = 2'd1;
   localparam logic [1:0] PH_CMD  = 2'd2;
   localparam logic [1:0] PH_DATA = 2'd3;

   logic [1:0]         phase_ff, phase_in;
   logic [BYTE_W-1:0]  cmd_ff, cmd_in;
   logic [BYTE_W-1:0]  data_ff, data_in;
   logic [MS_W-1:0]    start_ff, start_in;
   logic [COUNT_W-1:0] tmo_ff, tmo_in;
   logic [COUNT_W-1:0] err_ff, err_in;
   logic               is_mark;
   logic [MS_W-1:0]    elapsed;
   logic [1:0]         ev;
   logic [BYTE_W-1:0]  out_cmd, out_data;

   assign is_mark = (item.rx_byte == cfg.frame_marker);
   assign elapsed = item.now_ms - start_ff;

   always_comb begin
      phase_in = phase_ff;
      cmd_in   = cmd_ff;
      data_in  = data_ff;
      start_in = start_ff;
      tmo_in   = tmo_ff;
      err_in   = err_ff;
      ev       = EV_NONE;
      out_cmd  = '0;
      out_data = '0;
      unique case (item.func)
         FUNC_BYTE: begin
            unique case (phase_ff)
               PH_IDLE: begin
                  if (is_mark) begin
                     phase_in = PH_MARK;
                     start_in = item.now_ms;
                  end
               end
               PH_MARK: begin
                  if (is_mark) begin
                     start_in = item.now_ms;
                  end else begin
                     cmd_in   = item.rx_byte;
                     phase_in = PH_CMD;
                  end
               end
               PH_CMD: begin
                  if (is_mark) begin
                     phase_in = PH_MARK;
                     start_in = item.now_ms;
                  end else begin
                     data_in  = item.rx_byte;
                     phase_in = PH_DATA;
                  end
               end
               default: begin
                  if (is_mark) begin
                     ev       = EV_FRAME;
                     out_cmd  = cmd_ff;
                     out_data = data_ff;
                  end else begin
                     ev     = EV_BAD_TRAILER;
                     err_in = err_ff + 1'b1;
                  end
                  phase_in = PH_IDLE;
               end
            endcase
         end
         FUNC_CHECK: begin
            if (phase_ff != PH_IDLE && elapsed >= cfg.timeout_limit_ms) begin
               phase_in = PH_IDLE;
               cmd_in   = '0;
               data_in  = '0;
               tmo_in   = tmo_ff + 1'b1;
               ev       = EV_TIMEOUT;
            end
         end
         FUNC_CLEAR: begin
            phase_in = PH_IDLE;
            cmd_in   = '0;
            data_in  = '0;
            start_in = '0;
            tmo_in   = '0;
            err_in   = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cmd_ff   <= '0;
         data_ff  <= '0;
         start_ff <= '0;
         tmo_ff   <= '0;
         err_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         data_ff  <= data_in;
         start_ff <= start_in;
         tmo_ff   <= tmo_in;
         err_ff   <= err_in;
      end
   end

   assign result.event_res     = ev;
   assign result.frame_cmd     = out_cmd;
   assign result.frame_data    = out_data;
   assign result.timeout_drops = tmo_in;
   assign result.error_drops   = err_in;

endmodule

// ===== hw/rtl/marker_framed_command_parser_top.sv =====
// marker framed command parser top level: input register, parser, result register
//
// Parses MARKER CMD DATA MARKER frames one byte per transfer, with timeout
// checks and a parser/statistics reset on the same channel. Each request
// transfer yields exactly one response transfer carrying the frame event and
// both drop counters as they stand after that request. The block takes one
// request per cycle unless stalled by rsp_stall; a request is held in the input
// register, passes once through the parser compare-and-update logic and is
// then written into the response register, from which its response is
// offered. req_stall follows rsp_stall only when both registers hold data.
// Configuration writes are always ready and should be issued while no
// request is in flight.
module marker_framed_command_parser_top
   import mfcp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;
   rsp_type result;
   req_type item_ff;
   logic    item_valid_ff;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   logic    advance;
   logic    load;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = item_valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   mfcp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mfcp_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (item_valid_ff && advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (!item_valid_ff || advance) begin
            item_valid_ff <= load;
         end
         if (advance) begin
            rsp_valid_ff <= item_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_data;
      end
      if (advance && item_valid_ff) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
